// ===== src/oans_pkg.sv =====
// shared types and constants of the obstacle avoidance navigation sequencer
`timescale 1ns / 1ps
package oans_pkg;

  localparam int QUEUE_DEPTH   = 6;
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam logic [6:0] REVERSE_SPEED = 7'd50;

  typedef logic [2:0] kind_t;
  typedef logic [2:0] motion_t;
  typedef logic [QCNT_W-1:0] qcnt_t;

  localparam kind_t K_NONE    = 3'd0;
  localparam kind_t K_PAUSE   = 3'd1;
  localparam kind_t K_REVERSE = 3'd2;
  localparam kind_t K_BACKOFF = 3'd3;
  localparam kind_t K_LEFT    = 3'd4;
  localparam kind_t K_RIGHT   = 3'd5;
  localparam kind_t K_UTURN   = 3'd6;

  localparam motion_t MV_STOP  = 3'd0;
  localparam motion_t MV_FWD   = 3'd1;
  localparam motion_t MV_BACK  = 3'd2;
  localparam motion_t MV_LEFT  = 3'd3;
  localparam motion_t MV_RIGHT = 3'd4;

  localparam logic [2:0] SCENE_CLEAR = 3'd0;
  localparam logic [2:0] SCENE_FRONT = 3'd1;
  localparam logic [2:0] SCENE_LEFT  = 3'd2;
  localparam logic [2:0] SCENE_RIGHT = 3'd3;
  localparam logic [2:0] SCENE_ALL   = 3'd4;

  localparam logic [2:0] REG_PAUSE     = 3'd0;
  localparam logic [2:0] REG_REVERSE   = 3'd1;
  localparam logic [2:0] REG_BACKOFF   = 3'd2;
  localparam logic [2:0] REG_TURN90    = 3'd3;
  localparam logic [2:0] REG_TURN180   = 3'd4;
  localparam logic [2:0] REG_CNT_MAX   = 3'd5;
  localparam logic [2:0] REG_SPEED_FWD = 3'd6;
  localparam logic [2:0] REG_SPEED_TRN = 3'd7;

  typedef struct packed {
    logic        front_obst;
    logic        left_obst;
    logic        right_obst;
    logic        mark_edge;
    logic        mark_level;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0] motion;
    logic [6:0] speed_percent;
    logic [7:0] counter_value;
    logic [2:0] scene;
    logic       halted;
    logic       obstacle_led;
    logic       mark_led;
    logic       beep_mark;
    logic       beep_obstacle;
    logic       done_signal;
  } out_item_t;

  typedef struct packed {
    logic  clear;
    logic  pop;
    logic  load;
    qcnt_t load_cnt;
    kind_t load_k0;
    kind_t load_k1;
  } q_ctrl_t;

endpackage

// ===== src/oans_queue.sv =====
// action queue: shift register of action kinds with clear, load and pop
`timescale 1ns / 1ps
module oans_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  oans_pkg::q_ctrl_t ctrl,
  output oans_pkg::kind_t   head,
  output oans_pkg::qcnt_t   count
);
  import oans_pkg::*;

  kind_t entries_r [QUEUE_DEPTH];
  qcnt_t count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctrl.clear) begin
      count_r <= '0;
    end else if (ctrl.load) begin
      count_r <= ctrl.load_cnt;
    end else if (ctrl.pop && count_r != '0) begin
      count_r <= count_r - qcnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      entries_r[0] <= ctrl.load_k0;
      entries_r[1] <= ctrl.load_k1;
    end else if (ctrl.pop) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        entries_r[i] <= entries_r[i + 1];
      end
    end
  end

  assign head  = entries_r[0];
  assign count = count_r;

endmodule

// ===== src/obstacle_avoid_nav_sequencer_core.sv =====
// top level of the obstacle avoidance navigation sequencer
//
//  channel | ports                          | direction | payload
//  --------+--------------------------------+-----------+-----------
//  input   | in_valid, in_stall, in_item    | in        | in_item_t
//  result  | out_valid, out_stall, out_item | out       | out_item_t
//  config  | cfg_we, cfg_index, cfg_wdata   | in        | 16 bit
//
// one item per cycle while in_stall is low; each item gives its result item in the cycle after it is accepted
// the whole tick decision is one combinational pass from the state registers
// and the accepted item into the state and output registers
// in_stall is high only while a result item waits and out_stall is high
// synchronous active-low reset; no clearing pass
`timescale 1ns / 1ps
module obstacle_avoid_nav_sequencer_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  oans_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output oans_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);
  import oans_pkg::*;

  // config registers
  logic [15:0] pause_ms_r, reverse_ms_r, backoff_ms_r, turn90_ms_r, turn180_ms_r;
  logic [7:0]  counter_max_r;
  logic [6:0]  speed_forward_r, speed_turn_r;

  // tick state
  logic        act_valid_r, act_valid_nxt;
  kind_t       act_kind_r, act_kind_nxt;
  logic [31:0] act_start_r, act_start_nxt;
  logic [7:0]  mark_count_r, mark_count_nxt;
  logic        count_down_r, count_down_nxt;
  logic [2:0]  scene_r, scene_nxt;
  motion_t     motion_r, motion_nxt;
  logic        halt_r, halt_nxt;
  logic        cd_mode_r, cd_mode_nxt;
  logic        toggle_r, toggle_nxt;
  logic        last_front_r;

  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_item_r, out_item_nxt;

  q_ctrl_t     q_ctrl;
  kind_t       q_head;
  qcnt_t       q_count;

  logic        accept;
  logic        done;
  logic [15:0] dur;
  logic [31:0] elapsed;
  logic [6:0]  speed;
  kind_t       first_kind;

  function automatic motion_t kind_motion(input kind_t k);
    case (k)
      K_REVERSE, K_BACKOFF: kind_motion = MV_BACK;
      K_LEFT:               kind_motion = MV_LEFT;
      K_RIGHT, K_UTURN:     kind_motion = MV_RIGHT;
      default:              kind_motion = MV_STOP;
    endcase
  endfunction

  function automatic logic kind_down(input kind_t k);
    kind_down = (k == K_REVERSE) || (k == K_BACKOFF);
  endfunction

  oans_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (q_ctrl),
    .head  (q_head),
    .count (q_count)
  );

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pause_ms_r      <= 16'd200;
      reverse_ms_r    <= 16'd600;
      backoff_ms_r    <= 16'd300;
      turn90_ms_r     <= 16'd400;
      turn180_ms_r    <= 16'd800;
      counter_max_r   <= 8'd99;
      speed_forward_r <= 7'd60;
      speed_turn_r    <= 7'd50;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PAUSE:     pause_ms_r      <= cfg_wdata;
        REG_REVERSE:   reverse_ms_r    <= cfg_wdata;
        REG_BACKOFF:   backoff_ms_r    <= cfg_wdata;
        REG_TURN90:    turn90_ms_r     <= cfg_wdata;
        REG_TURN180:   turn180_ms_r    <= cfg_wdata;
        REG_CNT_MAX:   counter_max_r   <= cfg_wdata[7:0];
        REG_SPEED_FWD: speed_forward_r <= cfg_wdata[6:0];
        REG_SPEED_TRN: speed_turn_r    <= cfg_wdata[6:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (act_kind_r)
      K_PAUSE:         dur = pause_ms_r;
      K_REVERSE:       dur = reverse_ms_r;
      K_BACKOFF:       dur = backoff_ms_r;
      K_LEFT, K_RIGHT: dur = turn90_ms_r;
      K_UTURN:         dur = turn180_ms_r;
      default:         dur = 16'd0;
    endcase
  end

  assign elapsed = in_item.now_ms - act_start_r;

  always_comb begin
    act_valid_nxt  = act_valid_r;
    act_kind_nxt   = act_kind_r;
    act_start_nxt  = act_start_r;
    mark_count_nxt = mark_count_r;
    count_down_nxt = count_down_r;
    scene_nxt      = scene_r;
    motion_nxt     = motion_r;
    halt_nxt       = halt_r;
    cd_mode_nxt    = cd_mode_r;
    toggle_nxt     = toggle_r;
    q_ctrl         = '0;
    done           = 1'b0;
    first_kind     = K_NONE;

    // mark counter
    if (in_item.mark_edge) begin
      if (!count_down_r) begin
        if (mark_count_r < counter_max_r) begin
          mark_count_nxt = mark_count_r + 8'd1;
        end
      end else if (mark_count_r != 8'd0) begin
        mark_count_nxt = mark_count_r - 8'd1;
      end
      if (cd_mode_r && mark_count_nxt == 8'd0) begin
        halt_nxt      = 1'b1;
        act_valid_nxt = 1'b0;
        q_ctrl.clear  = 1'b1;
        motion_nxt    = MV_STOP;
        done          = 1'b1;
      end
    end

    if (halt_nxt) begin
      motion_nxt = MV_STOP;
    end else begin
      // active action timeout
      if (act_valid_r && elapsed >= {16'd0, dur}) begin
        act_valid_nxt = 1'b0;
        motion_nxt    = MV_STOP;
      end
      // start next queued action
      if (!act_valid_nxt && q_count != '0) begin
        q_ctrl.pop     = 1'b1;
        act_kind_nxt   = q_head;
        act_valid_nxt  = 1'b1;
        act_start_nxt  = in_item.now_ms;
        motion_nxt     = kind_motion(q_head);
        count_down_nxt = kind_down(q_head) | cd_mode_r;
      end

      if (act_valid_nxt || q_count != '0) begin
        // busy with a sequence
      end else if (!in_item.front_obst) begin
        scene_nxt = SCENE_CLEAR;
        if (cd_mode_r) begin
          count_down_nxt = 1'b1;
          if (mark_count_nxt == 8'd0) begin
            halt_nxt   = 1'b1;
            motion_nxt = MV_STOP;
            done       = 1'b1;
          end else begin
            motion_nxt = MV_FWD;
          end
        end else begin
          count_down_nxt = 1'b0;
          motion_nxt     = MV_FWD;
        end
      end else begin
        // plan avoidance; first action starts at once, the rest is queued
        q_ctrl.load = 1'b1;
        case ({in_item.left_obst, in_item.right_obst})
          2'b00: begin
            scene_nxt       = SCENE_FRONT;
            cd_mode_nxt     = 1'b0;
            first_kind      = K_PAUSE;
            q_ctrl.load_k0  = K_REVERSE;
            q_ctrl.load_k1  = toggle_r ? K_RIGHT : K_LEFT;
            q_ctrl.load_cnt = qcnt_t'(2);
            toggle_nxt      = ~toggle_r;
          end
          2'b10: begin
            scene_nxt       = SCENE_LEFT;
            cd_mode_nxt     = 1'b0;
            first_kind      = K_BACKOFF;
            q_ctrl.load_k0  = K_RIGHT;
            q_ctrl.load_cnt = qcnt_t'(1);
          end
          2'b01: begin
            scene_nxt       = SCENE_RIGHT;
            cd_mode_nxt     = 1'b0;
            first_kind      = K_BACKOFF;
            q_ctrl.load_k0  = K_LEFT;
            q_ctrl.load_cnt = qcnt_t'(1);
          end
          default: begin
            scene_nxt       = SCENE_ALL;
            cd_mode_nxt     = 1'b1;
            first_kind      = K_BACKOFF;
            q_ctrl.load_k0  = K_UTURN;
            q_ctrl.load_cnt = qcnt_t'(1);
          end
        endcase
        act_kind_nxt   = first_kind;
        act_valid_nxt  = 1'b1;
        act_start_nxt  = in_item.now_ms;
        motion_nxt     = kind_motion(first_kind);
        count_down_nxt = kind_down(first_kind) | cd_mode_nxt;
      end
    end

    if (!accept) begin
      q_ctrl = '0;
    end
  end

  always_comb begin
    case (motion_nxt)
      MV_FWD:            speed = speed_forward_r;
      MV_BACK:           speed = REVERSE_SPEED;
      MV_LEFT, MV_RIGHT: speed = speed_turn_r;
      default:           speed = 7'd0;
    endcase
  end

  always_comb begin
    out_item_nxt.motion        = motion_nxt;
    out_item_nxt.speed_percent = speed;
    out_item_nxt.counter_value = mark_count_nxt;
    out_item_nxt.scene         = scene_nxt;
    out_item_nxt.halted        = halt_nxt;
    out_item_nxt.obstacle_led  = in_item.front_obst | in_item.left_obst |
                                 in_item.right_obst;
    out_item_nxt.mark_led      = in_item.mark_level;
    out_item_nxt.beep_mark     = in_item.mark_edge;
    out_item_nxt.beep_obstacle = in_item.front_obst & ~last_front_r;
    out_item_nxt.done_signal   = done;
  end

  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_valid_r  <= 1'b0;
      act_kind_r   <= K_NONE;
      act_start_r  <= 32'd0;
      mark_count_r <= 8'd0;
      count_down_r <= 1'b0;
      scene_r      <= SCENE_CLEAR;
      motion_r     <= MV_STOP;
      halt_r       <= 1'b0;
      cd_mode_r    <= 1'b0;
      toggle_r     <= 1'b0;
      last_front_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        act_valid_r  <= act_valid_nxt;
        act_kind_r   <= act_kind_nxt;
        act_start_r  <= act_start_nxt;
        mark_count_r <= mark_count_nxt;
        count_down_r <= count_down_nxt;
        scene_r      <= scene_nxt;
        motion_r     <= motion_nxt;
        halt_r       <= halt_nxt;
        cd_mode_r    <= cd_mode_nxt;
        toggle_r     <= toggle_nxt;
        last_front_r <= in_item.front_obst;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== src/oans_checker.sv =====
// port-level checks of the navigation sequencer and their bind
`timescale 1ns / 1ps
module oans_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input oans_pkg::out_item_t out_item
);
  import oans_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted item gave no result");

  a_stop_no_speed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.motion == MV_STOP |-> out_item.speed_percent == 7'd0)
    else $error("speed nonzero while stopped");

  a_done_halted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.done_signal |-> out_item.halted && out_item.motion == MV_STOP)
    else $error("done without halt");

  a_beep_obstacle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.beep_obstacle |-> out_item.obstacle_led)
    else $error("obstacle beep without obstacle");

endmodule

bind obstacle_avoid_nav_sequencer_core oans_checker u_oans_checker (.*);

// ===== sim/obstacle_avoid_nav_sequencer_core_tb.sv =====
// testbench for the navigation sequencer core: tick predictor, scoreboard, directed and random traffic
`timescale 1ns / 1ps
module obstacle_avoid_nav_sequencer_core_tb;
  import oans_pkg::*;

  localparam int PH_SHORT = 0;
  localparam int PH_MIN   = 1;
  localparam int PH_MAX   = 2;
  localparam int PH_WIDE  = 3;
  localparam int N_PHASE  = 8;
  localparam int PHASE_ITEMS = 250;
  localparam int QUIET_LIMIT = 2000;

  class nav_tick_scoreboard;
    bit [15:0]   reg_val [8];
    kind_t       act_q [QUEUE_DEPTH];
    int unsigned q_cnt;
    bit          act_valid;
    kind_t       act_kind;
    bit [31:0]   act_start;
    bit [7:0]    marks;
    bit          cnt_down;
    bit [2:0]    scene_r;
    motion_t     mot_r;
    bit          halted_r;
    bit          cd_mode;
    bit          turn_tgl;
    bit          prev_front;
    bit          done_r;
    out_item_t   expected_ticks[$];
    int          errors;

    function new();
      reg_val[REG_PAUSE]     = 16'd200;
      reg_val[REG_REVERSE]   = 16'd600;
      reg_val[REG_BACKOFF]   = 16'd300;
      reg_val[REG_TURN90]    = 16'd400;
      reg_val[REG_TURN180]   = 16'd800;
      reg_val[REG_CNT_MAX]   = 16'd99;
      reg_val[REG_SPEED_FWD] = 16'd60;
      reg_val[REG_SPEED_TRN] = 16'd50;
      foreach (act_q[i]) act_q[i] = K_NONE;
      q_cnt      = 0;
      act_valid  = 1'b0;
      act_kind   = K_NONE;
      act_start  = '0;
      marks      = '0;
      cnt_down   = 1'b0;
      scene_r    = SCENE_CLEAR;
      mot_r      = MV_STOP;
      halted_r   = 1'b0;
      cd_mode    = 1'b0;
      turn_tgl   = 1'b0;
      prev_front = 1'b0;
      done_r     = 1'b0;
      errors     = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        REG_CNT_MAX: reg_val[idx] = {8'd0, val[7:0]};
        REG_SPEED_FWD, REG_SPEED_TRN: reg_val[idx] = {9'd0, val[6:0]};
        default: reg_val[idx] = val;
      endcase
    endfunction

    function void push_action(kind_t k);
      if (q_cnt < QUEUE_DEPTH) begin
        act_q[q_cnt] = k;
        q_cnt++;
      end
    endfunction

    function bit [31:0] action_len(kind_t k);
      case (k)
        K_PAUSE: return {16'd0, reg_val[REG_PAUSE]};
        K_REVERSE: return {16'd0, reg_val[REG_REVERSE]};
        K_BACKOFF: return {16'd0, reg_val[REG_BACKOFF]};
        K_LEFT, K_RIGHT: return {16'd0, reg_val[REG_TURN90]};
        K_UTURN: return {16'd0, reg_val[REG_TURN180]};
        default: return 32'd0;
      endcase
    endfunction

    function void stop_all();
      halted_r  = 1'b1;
      act_valid = 1'b0;
      q_cnt     = 0;
      mot_r     = MV_STOP;
      done_r    = 1'b1;
    endfunction

    function void set_motion(kind_t k);
      case (k)
        K_REVERSE, K_BACKOFF: mot_r = MV_BACK;
        K_LEFT: mot_r = MV_LEFT;
        K_RIGHT, K_UTURN: mot_r = MV_RIGHT;
        default: mot_r = MV_STOP;
      endcase
      cnt_down = (k == K_REVERSE || k == K_BACKOFF) ? 1'b1 : cd_mode;
    endfunction

    function void launch_next(bit [31:0] now);
      if (halted_r || act_valid || q_cnt == 0) return;
      act_kind = act_q[0];
      for (int i = 1; i < q_cnt; i++) act_q[i-1] = act_q[i];
      q_cnt--;
      act_valid = 1'b1;
      act_start = now;
      set_motion(act_kind);
    endfunction

    function out_item_t build(in_item_t it, bit obst, bit bo);
      out_item_t r;
      case (mot_r)
        MV_FWD: r.speed_percent = reg_val[REG_SPEED_FWD][6:0];
        MV_BACK: r.speed_percent = REVERSE_SPEED;
        MV_LEFT, MV_RIGHT: r.speed_percent = reg_val[REG_SPEED_TRN][6:0];
        default: r.speed_percent = 7'd0;
      endcase
      r.motion        = mot_r;
      r.counter_value = marks;
      r.scene         = scene_r;
      r.halted        = halted_r;
      r.obstacle_led  = obst;
      r.mark_led      = it.mark_level;
      r.beep_mark     = it.mark_edge;
      r.beep_obstacle = bo;
      r.done_signal   = done_r;
      return r;
    endfunction

    function out_item_t step_nav(in_item_t it);
      bit front, left, right, obst, bo;
      bit [31:0] elapsed;
      front = it.front_obst;
      left  = it.left_obst;
      right = it.right_obst;
      obst  = front | left | right;
      done_r = 1'b0;
      if (it.mark_edge) begin
        if (!cnt_down) begin
          if (marks < reg_val[REG_CNT_MAX][7:0]) marks++;
        end else if (marks > 0) begin
          marks--;
        end
        if (cd_mode && marks == 0) stop_all();
      end
      bo = front && !prev_front;
      prev_front = front;
      if (halted_r) begin
        mot_r = MV_STOP;
        return build(it, obst, bo);
      end
      elapsed = it.now_ms - act_start;
      if (act_valid && elapsed >= action_len(act_kind)) begin
        act_valid = 1'b0;
        mot_r = MV_STOP;
      end
      launch_next(it.now_ms);
      if (act_valid || q_cnt != 0) return build(it, obst, bo);
      if (!front) begin
        scene_r = SCENE_CLEAR;
        if (cd_mode) begin
          cnt_down = 1'b1;
          if (marks == 0) begin
            stop_all();
            return build(it, obst, bo);
          end
        end else begin
          cnt_down = 1'b0;
        end
        mot_r = MV_FWD;
        return build(it, obst, bo);
      end
      q_cnt = 0;
      if (!left && !right) begin
        scene_r = SCENE_FRONT;
        cd_mode = 1'b0;
        push_action(K_PAUSE);
        push_action(K_REVERSE);
        push_action(turn_tgl ? K_RIGHT : K_LEFT);
        turn_tgl = !turn_tgl;
      end else if (left && !right) begin
        scene_r = SCENE_LEFT;
        cd_mode = 1'b0;
        push_action(K_BACKOFF);
        push_action(K_RIGHT);
      end else if (!left && right) begin
        scene_r = SCENE_RIGHT;
        cd_mode = 1'b0;
        push_action(K_BACKOFF);
        push_action(K_LEFT);
      end else begin
        scene_r  = SCENE_ALL;
        cd_mode  = 1'b1;
        cnt_down = 1'b1;
        push_action(K_BACKOFF);
        push_action(K_UTURN);
      end
      launch_next(it.now_ms);
      return build(it, obst, bo);
    endfunction

    function void note_input(in_item_t it);
      expected_ticks.push_back(step_nav(it));
    endfunction

    function int pending();
      return expected_ticks.size();
    endfunction

    function void cmp(string name, logic [31:0] e, logic [31:0] g);
      if (g !== e) begin
        $error("%s: expected %0d, got %0d", name, e, g);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (expected_ticks.size() == 0) begin
        $error("result item with no expected item pending");
        errors++;
        return;
      end
      e = expected_ticks.pop_front();
      cmp("motion", e.motion, got.motion);
      cmp("speed_percent", e.speed_percent, got.speed_percent);
      cmp("counter_value", e.counter_value, got.counter_value);
      cmp("scene", e.scene, got.scene);
      cmp("halted", e.halted, got.halted);
      cmp("obstacle_led", e.obstacle_led, got.obstacle_led);
      cmp("mark_led", e.mark_led, got.mark_led);
      cmp("beep_mark", e.beep_mark, got.beep_mark);
      cmp("beep_obstacle", e.beep_obstacle, got.beep_obstacle);
      cmp("done_signal", e.done_signal, got.done_signal);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_PAUSE;
  logic [15:0] cfg_wdata = '0;

  nav_tick_scoreboard sb = new();
  bit          no_idle = 1'b0;
  bit          hold_go = 1'b0;
  bit [31:0]   cur_now = '0;
  bit [15:0]   cfg_vals [8];
  int unsigned quiet_cycles = 0;

  obstacle_avoid_nav_sequencer_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side: check accepted items, random stall, one long hold-off on request
  initial begin
    int hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
      if (hold_go) begin
        hold_go = 1'b0;
        hold_cnt = 80;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !no_idle && ($urandom_range(0, 99) < 28);
      end
    end
  end

  task automatic drive_item(in_item_t it);
    while (!no_idle && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_input(it);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic program_regs(int mode);
    foreach (cfg_vals[i]) cfg_vals[i] = '0;
    case (mode)
      PH_MIN: ;
      PH_MAX: begin
        cfg_vals[REG_PAUSE]     = 16'hFFFF;
        cfg_vals[REG_REVERSE]   = 16'hFFFF;
        cfg_vals[REG_BACKOFF]   = 16'hFFFF;
        cfg_vals[REG_TURN90]    = 16'hFFFF;
        cfg_vals[REG_TURN180]   = 16'hFFFF;
        cfg_vals[REG_CNT_MAX]   = 16'd255;
        cfg_vals[REG_SPEED_FWD] = 16'd100;
        cfg_vals[REG_SPEED_TRN] = 16'd100;
      end
      default: begin
        for (int i = REG_PAUSE; i <= REG_TURN180; i++) begin
          if (mode == PH_WIDE && $urandom_range(0, 2) == 0) begin
            cfg_vals[i] = 16'($urandom_range(0, 65535));
          end else begin
            cfg_vals[i] = 16'($urandom_range(0, 60));
          end
        end
        cfg_vals[REG_CNT_MAX] = ($urandom_range(0, 3) == 0) ?
                                16'($urandom_range(0, 255)) : 16'($urandom_range(2, 12));
        cfg_vals[REG_SPEED_FWD] = 16'($urandom_range(0, 100));
        cfg_vals[REG_SPEED_TRN] = 16'($urandom_range(0, 100));
      end
    endcase
    for (int i = REG_PAUSE; i <= REG_SPEED_TRN; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      cfg_wdata <= cfg_vals[i];
      sb.set_reg(3'(i), cfg_vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic in_item_t mk(bit f, bit l, bit r, bit e, bit lv, bit [31:0] t);
    in_item_t it;
    it.front_obst = f;
    it.left_obst  = l;
    it.right_obst = r;
    it.mark_edge  = e;
    it.mark_level = lv;
    it.now_ms     = t;
    return it;
  endfunction

  // steering keeps the countdown from reaching zero so the block does not halt early
  function automatic in_item_t next_random(bit steer);
    in_item_t it;
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) cur_now = cur_now + $urandom_range(0, 15);
    else if (r < 95) cur_now = cur_now + $urandom_range(0, 70000);
    else cur_now = $urandom();
    it = mk($urandom_range(0, 99) < 40, $urandom_range(0, 1), $urandom_range(0, 1),
            $urandom_range(0, 99) < 25, $urandom_range(0, 1), cur_now);
    if (steer) begin
      if (it.front_obst && it.left_obst && it.right_obst && sb.marks < 2)
        it.right_obst = 1'b0;
      if (sb.cd_mode && sb.marks <= 1) begin
        it.front_obst = 1'b1;
        if (it.left_obst && it.right_obst) it.left_obst = 1'b0;
        it.mark_edge = 1'b0;
      end
    end
    return it;
  endfunction

  task automatic run_directed();
    bit [31:0] base_ms;
    base_ms = 32'hFFFF_FF00;
    drive_item(mk(0, 0, 0, 0, 0, base_ms));
    drive_item(mk(0, 0, 0, 1, 1, base_ms + 32'd1));
    drive_item(mk(1, 0, 0, 0, 0, base_ms + 32'd2));
    drive_item(mk(1, 1, 1, 1, 1, base_ms + 32'd100));
    drive_item(mk(1, 0, 0, 0, 0, base_ms + 32'd202));
    drive_item(mk(0, 0, 0, 1, 0, base_ms + 32'd500));
    drive_item(mk(0, 0, 0, 0, 0, base_ms + 32'd802));
    drive_item(mk(0, 0, 0, 0, 0, base_ms + 32'd1202));
    drive_item(mk(1, 1, 0, 0, 1, base_ms + 32'd1300));
    drive_item(mk(1, 0, 1, 0, 0, base_ms + 32'd1600));
    drive_item(mk(0, 0, 0, 0, 0, base_ms + 32'd2000));
    drive_item(mk(1, 0, 1, 0, 0, base_ms + 32'd2001));
    drive_item(mk(0, 0, 0, 0, 0, base_ms + 32'd2301));
    drive_item(mk(1, 0, 0, 0, 0, base_ms + 32'd2701));
    drive_item(mk(0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    drive_item(mk(0, 0, 0, 1, 1, 32'h0000_0000));
    drive_item(mk(1, 1, 1, 0, 0, 32'h0000_0001));
    cur_now = 32'h0000_0001;
  endtask

  initial begin
    int phase_mode [N_PHASE] = '{PH_SHORT, PH_MAX, PH_MIN, PH_SHORT,
                                 PH_WIDE, PH_SHORT, PH_WIDE, PH_SHORT};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (int p = 0; p < N_PHASE; p++) begin
      wait_idle();
      program_regs(phase_mode[p]);
      no_idle = (p == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 5 && n == 40) hold_go = 1'b1;
        drive_item(next_random(p != N_PHASE - 1));
      end
    end
    no_idle = 1'b0;
    wait_idle();
    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
